@@ rtl/edc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Elias delta codec package
// Shared widths, status codes and transaction types for the codec.
// ----------------------------------------------------------------------------
package edc_pkg;

    localparam int VALUE_WIDTH  = 32;
    localparam int WINDOW_WIDTH = 64;
    localparam int MAX_LZ       = 5;

    localparam int VALUE_PORT_W  = 32;
    localparam int WINDOW_PORT_W = 64;
    localparam int CODE_W        = 42;
    localparam int LEN_W         = 6;
    localparam int STATUS_W      = 2;

    localparam int NW     = $clog2(VALUE_WIDTH);
    localparam int LW     = $clog2(NW + 1);
    localparam int TOP_W  = VALUE_WIDTH + 2 * MAX_LZ + 1;
    localparam int PFX_W  = MAX_LZ + 1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MALFORMED = 2'd2;

    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    typedef struct packed {
        logic                     command;
        logic [VALUE_PORT_W-1:0]  value_in;
        logic [WINDOW_PORT_W-1:0] window;
    } t_item;

    typedef struct packed {
        logic [CODE_W-1:0]       code_word;
        logic [LEN_W-1:0]        code_length;
        logic [VALUE_PORT_W-1:0] value_out;
        logic [STATUS_W-1:0]     status;
    } t_result;

endpackage
`default_nettype wire

@@ rtl/edc_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Elias delta codec channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface edc_in_if
    import edc_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     command;
    logic [VALUE_PORT_W-1:0]  value_in;
    logic [WINDOW_PORT_W-1:0] window;

    modport source (output valid, output command, output value_in, output window,
                    input ready);
    modport sink   (input valid, input command, input value_in, input window,
                    output ready);
endinterface

interface edc_out_if
    import edc_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [CODE_W-1:0]       code_word;
    logic [LEN_W-1:0]        code_length;
    logic [VALUE_PORT_W-1:0] value_out;
    logic [STATUS_W-1:0]     status;

    modport source (output valid, output code_word, output code_length,
                    output value_out, output status, input ready);
    modport sink   (input valid, input code_word, input code_length,
                    input value_out, input status, output ready);
endinterface
`default_nettype wire

@@ rtl/edc_encode.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Elias delta encoder
// Builds one right-aligned delta code and its length from a value.
// ----------------------------------------------------------------------------
module edc_encode
    import edc_pkg::*;
(
    input  wire logic [VALUE_PORT_W-1:0] i_value,
    output t_result                      o_result
);

    logic [VALUE_WIDTH-1:0] v;
    logic [VALUE_WIDTH-1:0] x;
    logic [NW-1:0]          n;
    logic [NW:0]            np1;
    logic [LW-1:0]          l;
    logic [CODE_W-1:0]      word;

    always_comb begin
        v = i_value[VALUE_WIDTH-1:0];
        x = v + VALUE_WIDTH'(1);
        n = '0;
        for (int i = 0; i < VALUE_WIDTH; i++) begin
            if (x[i]) begin
                n = NW'(i);
            end
        end
        np1 = {1'b0, n} + (NW+1)'(1);
        l = '0;
        for (int i = 0; i <= NW; i++) begin
            if (np1[i]) begin
                l = LW'(i);
            end
        end
        word = (CODE_W'(np1) << n) | (CODE_W'(x) & ~(CODE_W'(1) << n));

        o_result = '0;
        if (&v) begin
            o_result.status = ST_TOO_LARGE;
        end else begin
            o_result.status      = ST_OK;
            o_result.code_word   = word;
            o_result.code_length = LEN_W'({l, 1'b1}) + LEN_W'(n);
        end
    end

endmodule
`default_nettype wire

@@ rtl/edc_decode.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Elias delta decoder
// Reads one delta code from the top of a window and returns value and length.
// ----------------------------------------------------------------------------
module edc_decode
    import edc_pkg::*;
(
    input  wire logic [WINDOW_PORT_W-1:0] i_window,
    output t_result                       o_result
);

    logic [TOP_W-1:0]       t;
    logic [TOP_W-1:0]       tl;
    logic [TOP_W-1:0]       tp;
    logic                   found;
    logic [LW-1:0]          l;
    logic [PFX_W-1:0]       m;
    logic [PFX_W-1:0]       n6;
    logic                   bad_n;
    logic [LW:0]            pos;
    logic [VALUE_WIDTH-1:0] top;
    logic [NW:0]            sh;
    logic [VALUE_WIDTH-1:0] field;
    logic [VALUE_WIDTH-1:0] xval;

    always_comb begin
        t     = i_window[WINDOW_WIDTH-1 -: TOP_W];
        found = 1'b0;
        l     = '0;
        for (int i = 0; i <= MAX_LZ; i++) begin
            if (!found && t[TOP_W-1-i]) begin
                found = 1'b1;
                l     = LW'(i);
            end
        end
        tl    = t << l;
        m     = tl[TOP_W-1 -: PFX_W] >> (LW'(MAX_LZ) - l);
        n6    = m - PFX_W'(1);
        bad_n = n6 > PFX_W'(VALUE_WIDTH - 1);
        pos   = {l, 1'b1};
        tp    = t << pos;
        top   = tp[TOP_W-1 -: VALUE_WIDTH];
        sh    = (NW+1)'(VALUE_WIDTH) - (NW+1)'(n6);
        field = top >> sh;
        xval  = (VALUE_WIDTH'(1) << n6[NW-1:0]) | field;

        o_result = '0;
        if (!found || bad_n) begin
            o_result.status = ST_MALFORMED;
        end else begin
            o_result.status      = ST_OK;
            o_result.value_out   = VALUE_PORT_W'(xval - VALUE_WIDTH'(1));
            o_result.code_length = LEN_W'(pos) + LEN_W'(n6);
        end
    end

endmodule
`default_nettype wire

@@ rtl/elias_delta_codec.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Elias delta codec
// Encodes a value or decodes a window into one Elias delta code per item.
//
// Each input transaction on i_in carries a command with either a value to
// encode or a 64-bit window whose top bit is the first code bit. Every input
// transaction yields exactly one result transaction on o_out carrying the
// code word and length, the decoded value, and a status code.
// The block is a two-register pipeline: an input register, the encoder and
// decoder logic, and a result register. Each item passes through the input
// register and then the result register before o_out.valid shows it, and one
// item is taken every cycle as long as the receiver takes results. When
// o_out.ready is low the result register holds, the input register still
// takes one more item if it is empty, and then i_in.ready drops until the
// receiver resumes; nothing is lost or repeated. Reset empties both
// registers; no other state is kept.
// ----------------------------------------------------------------------------
module elias_delta_codec
    import edc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    edc_in_if.sink    i_in,
    edc_out_if.source o_out
);

    t_item   r_s1;
    logic    r_s1_vld;
    t_result r_res;
    logic    r_o_vld;

    t_result enc_res;
    t_result dec_res;
    t_result n_res;
    logic    s2_load;
    logic    s1_ready;

    edc_encode u_enc (
        .i_value  (r_s1.value_in),
        .o_result (enc_res)
    );

    edc_decode u_dec (
        .i_window (r_s1.window),
        .o_result (dec_res)
    );

    assign n_res    = (r_s1.command == CMD_DECODE) ? dec_res : enc_res;
    assign s2_load  = !r_o_vld || o_out.ready;
    assign s1_ready = !r_s1_vld || s2_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_vld <= i_in.valid;
            end
            if (s2_load) begin
                r_o_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_in.valid) begin
            r_s1.command  <= i_in.command;
            r_s1.value_in <= i_in.value_in;
            r_s1.window   <= i_in.window;
        end
        if (s2_load && r_s1_vld) begin
            r_res <= n_res;
        end
    end

    assign i_in.ready        = s1_ready;
    assign o_out.valid       = r_o_vld;
    assign o_out.code_word   = r_res.code_word;
    assign o_out.code_length = r_res.code_length;
    assign o_out.value_out   = r_res.value_out;
    assign o_out.status      = r_res.status;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != ST_OK) |->
            (o_out.code_word == '0 && o_out.code_length == '0 && o_out.value_out == '0))
        else $error("error result carries nonzero fields");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !s2_load) |=> (r_s1_vld && $stable(r_s1)))
        else $error("input register lost a held item");

    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_s1_vld && r_o_vld))
        else $error("input stalled while pipeline not full");

    a_encode_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == ST_OK && o_out.code_word != '0) |->
            (o_out.value_out == '0 && o_out.code_length != '0))
        else $error("encode result inconsistent");

endmodule
`default_nettype wire

@@ sim/elias_delta_codec_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Elias delta codec testbench
// Sends encode and decode transactions to the codec and compares each result
// with a predictor of the code. The run covers directed corner cases,
// randomized traffic with well-formed and broken codes, a burst with no
// idling, and a long receiver stall that fills the pipeline.
// ----------------------------------------------------------------------------
module elias_delta_codec_test;
    import edc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 640;
    localparam int BURST_ITEMS    = 200;
    localparam int STALL_ITEMS    = 40;
    localparam int STALL_CYCLES   = 300;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    edc_in_if  in_ch ();
    edc_out_if out_ch ();

    elias_delta_codec u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_result pending_results[$];
    int      src_idle_pct = 30;
    int      sink_idle_pct = 30;
    int      stall_cycles_req = 0;
    int      fail_count = 0;
    int      encode_count = 0;
    int      decode_count = 0;
    int      error_status_count = 0;
    int      quiet_cycles = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int top_bit(logic [63:0] x);
        int n;
        n = 0;
        while (x > 64'd1) begin
            x = x >> 1;
            n++;
        end
        return n;
    endfunction

    function automatic logic [63:0] window_bits(logic [63:0] w, int pos, int len);
        return (w >> (WINDOW_WIDTH - pos - len)) & ((64'd1 << len) - 64'd1);
    endfunction

    function automatic t_result predict_code(logic cmd, logic [VALUE_PORT_W-1:0] val,
                                             logic [WINDOW_PORT_W-1:0] win);
        t_result     res;
        logic [63:0] vmask;
        logic [63:0] v;
        logic [63:0] x;
        logic [63:0] w;
        logic [63:0] m;
        logic [63:0] word;
        int          n;
        int          l;
        int          pos;
        res = '0;
        if (cmd == CMD_ENCODE) begin
            vmask = (64'd1 << VALUE_WIDTH) - 64'd1;
            v = 64'(val) & vmask;
            if (v == vmask) begin
                res.status = ST_TOO_LARGE;
            end else begin
                x = v + 64'd1;
                n = top_bit(x);
                l = top_bit(64'(n + 1));
                word = (64'(n + 1) << n) | (x & ((64'd1 << n) - 64'd1));
                res.code_word = word[CODE_W-1:0];
                res.code_length = LEN_W'(2 * l + 1 + n);
                res.status = ST_OK;
            end
        end else begin
            w = 64'(win);
            if (WINDOW_WIDTH < 64) begin
                w = w & ((64'd1 << WINDOW_WIDTH) - 64'd1);
            end
            l = 0;
            while (l <= MAX_LZ && window_bits(w, l, 1) == 64'd0) begin
                l++;
            end
            if (l > MAX_LZ) begin
                res.status = ST_MALFORMED;
            end else begin
                m = window_bits(w, l, l + 1);
                if (m - 64'd1 > 64'(VALUE_WIDTH - 1)) begin
                    res.status = ST_MALFORMED;
                end else begin
                    n = int'(m) - 1;
                    pos = 2 * l + 1;
                    x = (64'd1 << n) | window_bits(w, pos, n);
                    res.value_out = VALUE_PORT_W'(x - 64'd1);
                    res.code_length = LEN_W'(pos + n);
                    res.status = ST_OK;
                end
            end
        end
        return res;
    endfunction

    function automatic logic [VALUE_PORT_W-1:0] rand_value();
        case ($urandom_range(9))
            0: return '1;
            1: return 32'hFFFF_FFFE;
            2: return VALUE_PORT_W'($urandom_range(15));
            default: return $urandom >> $urandom_range(31);
        endcase
    endfunction

    function automatic logic [WINDOW_PORT_W-1:0] rand_window();
        t_result     enc;
        logic [63:0] noise;
        int          len;
        noise = {$urandom, $urandom};
        if ($urandom_range(99) < 70) begin
            enc = predict_code(CMD_ENCODE, rand_value(), '0);
            if (enc.status == ST_OK) begin
                len = int'(enc.code_length);
                return (64'(enc.code_word) << (64 - len))
                       | (noise & ((64'd1 << (64 - len)) - 64'd1));
            end
        end
        if ($urandom_range(19) == 0) begin
            return '0;
        end
        return noise >> $urandom_range(12);
    endfunction

    task automatic send_item(input logic cmd, input logic [VALUE_PORT_W-1:0] val,
                             input logic [WINDOW_PORT_W-1:0] win);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid = 1'b0;
            in_ch.value_in = $urandom;
            @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.command = cmd;
        in_ch.value_in = val;
        in_ch.window = win;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_results = {pending_results, predict_code(cmd, val, win)};
        @(negedge i_clk);
    endtask

    task automatic send_random_item();
        send_item(logic'($urandom_range(1)), rand_value(), rand_window());
    endtask

    task automatic test_directed_encode();
        logic [VALUE_PORT_W-1:0] values[12] = '{
            32'd0, 32'd1, 32'd2, 32'd6, 32'd7, 32'd14, 32'd15, 32'd30,
            32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF
        };
        foreach (values[i]) begin
            send_item(CMD_ENCODE, values[i], {$urandom, $urandom});
        end
    endtask

    task automatic test_directed_decode();
        logic [WINDOW_PORT_W-1:0] windows[9] = '{
            64'h8000_0000_0000_0000,
            64'hFFFF_FFFF_FFFF_FFFF,
            64'h0000_0000_0000_0000,
            64'h0200_0000_0000_0000,
            64'h4000_0000_0000_0000,
            {11'b00000100000, 53'd0},
            {11'b00000100000, {53{1'b1}}},
            {11'b00000100001, 53'd0},
            {11'b00000111111, {53{1'b1}}}
        };
        foreach (windows[i]) begin
            send_item(CMD_DECODE, $urandom, windows[i]);
        end
    endtask

    task automatic test_random_traffic();
        repeat (RANDOM_ITEMS) send_random_item();
    endtask

    task automatic test_no_idle_burst();
        src_idle_pct = 0;
        sink_idle_pct = 0;
        repeat (BURST_ITEMS) send_random_item();
        src_idle_pct = 30;
        sink_idle_pct = 30;
    endtask

    task automatic test_backpressure();
        src_idle_pct = 0;
        stall_cycles_req = STALL_CYCLES;
        repeat (STALL_ITEMS) send_random_item();
        src_idle_pct = 30;
    endtask

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            int stall_left;
            @(negedge i_clk);
            if (stall_cycles_req > 0) begin
                stall_left = stall_cycles_req;
                stall_cycles_req = 0;
            end
            if (stall_left > 0) begin
                out_ch.ready = 1'b0;
                stall_left--;
            end else begin
                out_ch.ready = ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result exp_res;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with no expected result");
                fail_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (out_ch.code_word !== exp_res.code_word) begin
                    $error("code_word expected %h, got %h", exp_res.code_word,
                           out_ch.code_word);
                    fail_count++;
                end
                if (out_ch.code_length !== exp_res.code_length) begin
                    $error("code_length expected %0d, got %0d", exp_res.code_length,
                           out_ch.code_length);
                    fail_count++;
                end
                if (out_ch.value_out !== exp_res.value_out) begin
                    $error("value_out expected %h, got %h", exp_res.value_out,
                           out_ch.value_out);
                    fail_count++;
                end
                if (out_ch.status !== exp_res.status) begin
                    $error("status expected %0d, got %0d", exp_res.status,
                           out_ch.status);
                    fail_count++;
                end
                if (exp_res.status != ST_OK) begin
                    error_status_count++;
                end
            end
        end
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            if (in_ch.command == CMD_ENCODE) begin
                encode_count++;
            end else begin
                decode_count++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding.",
                     pending_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.command = CMD_ENCODE;
        in_ch.value_in = '0;
        in_ch.window = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed_encode();
        test_directed_decode();
        test_random_traffic();
        test_no_idle_burst();
        test_backpressure();
        in_ch.valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        $display("Checked %0d encode and %0d decode transactions, %0d with an error status.",
                 encode_count, decode_count, error_status_count);
        $display("Traffic included random idling, a burst without gaps and a long stall.");
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
